// File: sv/gdda_pkg.sv
// Shared constants, types and helpers for the grid ray DDA traversal block.
// No dependencies.
package gdda_pkg;

  localparam int MapDim    = 64;
  localparam int FracBits  = 8;
  localparam int AddrW     = $clog2(MapDim);
  localparam int MapDepth  = MapDim * MapDim;
  localparam int MapAw     = 2 * AddrW;
  localparam int DistW     = 16 + FracBits;
  localparam int CellW     = 11;
  localparam int StartW    = AddrW + FracBits;
  localparam int QuotW     = 14 + FracBits + 1;

  localparam logic [DistW-1:0] DistMax = {DistW{1'b1}};

  localparam logic [1:0] CfgGridW = 2'd0;
  localparam logic [1:0] CfgGridH = 2'd1;
  localparam logic [1:0] CfgFar   = 2'd2;

  localparam logic ReqWrite = 1'b0;
  localparam logic ReqCast  = 1'b1;

  typedef enum logic [2:0] {
    CmdNone, CmdLoad, CmdDivStep, CmdSideMul, CmdWalk, CmdRead, CmdClear
  } gdda_cmd_e;

  typedef struct packed {
    gdda_cmd_e   op;
    logic        axis;
  } gdda_cmd_t;

  typedef struct packed {
    logic div_done;
    logic stop;
    logic clr_done;
  } gdda_sts_t;

  // Saturate a wide value to the distance width
  function automatic logic [DistW-1:0] sat_dist(input logic [2*DistW-1:0] v);
    if (v > {{DistW{1'b0}}, DistMax}) sat_dist = DistMax;
    else sat_dist = v[DistW-1:0];
  endfunction

endpackage

// File: sv/gdda_if.sv
// Valid/ready channel carrying one request or one result.
// No dependencies; widths are written as literals.
interface gdda_req_if (input logic clk_i);
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic [5:0]                   cell_x;
  logic [5:0]                   cell_y;
  logic                         cell_wall;
  logic [13:0]                  start_x;
  logic [13:0]                  start_y;
  logic signed [15:0]           dir_x;
  logic signed [15:0]           dir_y;
  modport source (output valid, req_type, cell_x, cell_y, cell_wall, start_x, start_y,
                  dir_x, dir_y, input ready);
  modport sink (input valid, req_type, cell_x, cell_y, cell_wall, start_x, start_y,
                dir_x, dir_y, output ready);
endinterface

interface gdda_res_if (input logic clk_i);
  logic               valid;
  logic               ready;
  logic               hit;
  logic               hit_side;
  logic signed [7:0]  hit_x;
  logic signed [7:0]  hit_y;
  logic [23:0]        distance;
  modport source (output valid, hit, hit_side, hit_x, hit_y, distance, input ready);
  modport sink (input valid, hit, hit_side, hit_x, hit_y, distance, output ready);
endinterface

// File: sv/gdda_ctrl.sv
// Sequencer for the ray caster: map clear, setup divides, first crossings, then walk.
// Depends on gdda_pkg.
module gdda_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_is_cast_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output gdda_pkg::gdda_cmd_t cmd_o,
  input  gdda_pkg::gdda_sts_t sts_i
);
  import gdda_pkg::*;

  typedef enum logic [2:0] {
    StClear, StIdle, StDivX, StDivY, StMul, StRead, StWalk, StDone
  } state_e;

  state_e state_q, state_d;
  logic   axis_q, axis_d;
  logic   out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == StIdle) && !out_valid_q;
  assign out_valid_o = out_valid_q;

  // Next state and datapath command
  always_comb begin
    state_d     = state_q;
    axis_d      = axis_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o.op    = CmdNone;
    cmd_o.axis  = axis_q;
    case (state_q)
      StClear: begin
        // wall map cleared one cell per cycle after reset
        cmd_o.op = CmdClear;
        if (sts_i.clr_done) state_d = StIdle;
      end
      StIdle: begin
        if (in_valid_i && in_ready_o) begin
          cmd_o.op = CmdLoad;
          if (in_is_cast_i) state_d = StDivX;
        end
      end
      StDivX: begin
        cmd_o.op   = CmdDivStep;
        cmd_o.axis = 1'b0;
        if (sts_i.div_done) state_d = StDivY;
      end
      StDivY: begin
        cmd_o.op   = CmdDivStep;
        cmd_o.axis = 1'b1;
        if (sts_i.div_done) begin
          state_d = StMul;
          axis_d  = 1'b0;
        end
      end
      StMul: begin
        cmd_o.op   = CmdSideMul;
        cmd_o.axis = axis_q;
        axis_d     = 1'b1;
        if (axis_q) state_d = StRead;
      end
      StRead: begin
        // stop check on the hit flag and the current distance
        if (sts_i.stop) begin
          state_d     = StDone;
        end else begin
          cmd_o.op = CmdWalk;
          state_d  = StWalk;
        end
      end
      StWalk: begin
        // registered map bit taken into the hit flag; result checked next cycle
        cmd_o.op = CmdRead;
        state_d  = StRead;
      end
      StDone: begin
        if (!out_valid_q) begin
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      axis_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      axis_q      <= axis_d;
      out_valid_q <= out_valid_d;
    end
  end
endmodule

// File: sv/gdda_dp.sv
// Datapath: wall map, restoring divider, step registers and result.
// Depends on gdda_pkg.
module gdda_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_type_i,
  input  logic [5:0]          cell_x_i,
  input  logic [5:0]          cell_y_i,
  input  logic                cell_wall_i,
  input  logic [13:0]         start_x_i,
  input  logic [13:0]         start_y_i,
  input  logic [15:0]         dir_x_i,
  input  logic [15:0]         dir_y_i,
  input  logic [6:0]          grid_w_i,
  input  logic [6:0]          grid_h_i,
  input  logic [15:0]         far_clip_i,
  input  gdda_pkg::gdda_cmd_t cmd_i,
  output gdda_pkg::gdda_sts_t sts_o,
  output logic                hit_o,
  output logic                side_o,
  output logic [7:0]          hit_x_o,
  output logic [7:0]          hit_y_o,
  output logic [23:0]         dist_o
);
  import gdda_pkg::*;

  // Wall map, cleared one cell per cycle after reset
  logic                 map_mem [MapDepth];
  logic [MapAw-1:0]     clr_addr_q;
  logic                 rd_bit_q;

  logic [StartW-1:0]    start_q [2];
  logic [15:0]          mag_q [2];
  logic                 neg_q [2];
  logic [DistW-1:0]     delta_q [2];
  logic [DistW-1:0]     lside_q [2];
  logic signed [CellW-1:0] cell_q [2];
  logic [DistW-1:0]     dist_q;
  logic                 hit_q, side_q;
  logic [6:0]           gw_q, gh_q;

  // Divider: 2^(14+F) / mag, one quotient bit per cycle
  logic [QuotW-1:0]     quo_q;
  logic [16:0]          rem_q;
  logic [$clog2(QuotW+1)-1:0] cnt_q;
  logic [16:0]          rem_sh;
  logic [15:0]          dmag;

  assign dmag   = mag_q[cmd_i.axis];
  assign rem_sh = {rem_q[15:0], (cnt_q == QuotW[$clog2(QuotW+1)-1:0])};
  assign sts_o.div_done = (cmd_i.op == CmdDivStep) &&
                          ((dmag == 16'd0) || (cnt_q == 1));
  assign sts_o.clr_done = (cmd_i.op == CmdClear) && (clr_addr_q == {MapAw{1'b1}});

  logic lx_lt;
  assign lx_lt = lside_q[0] < lside_q[1];
  assign sts_o.stop = hit_q || (dist_q >= {{(DistW-16){1'b0}}, far_clip_i});

  // next cell after a step, used as map read address
  logic signed [CellW-1:0] ncx, ncy;
  logic in_grid;
  always_comb begin
    ncx = cell_q[0];
    ncy = cell_q[1];
    if (lx_lt) ncx = cell_q[0] + (neg_q[0] ? -CellW'(1) : CellW'(1));
    else ncy = cell_q[1] + (neg_q[1] ? -CellW'(1) : CellW'(1));
  end
  assign in_grid = !cell_q[0][CellW-1] && !cell_q[1][CellW-1] &&
                   (cell_q[0] < $signed({{(CellW-7){1'b0}}, gw_q})) &&
                   (cell_q[1] < $signed({{(CellW-7){1'b0}}, gh_q}));

  logic [FracBits:0] mulf [2];
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      mulf[a] = neg_q[a] ? {1'b0, start_q[a][FracBits-1:0]}
                         : (FracBits+1)'((1 << FracBits) - int'(start_q[a][FracBits-1:0]));
    end
  end

  logic [2*DistW-1:0] prod;
  assign prod = (2*DistW)'((2*DistW)'(mulf[cmd_i.axis]) * (2*DistW)'(delta_q[cmd_i.axis]))
                >> FracBits;

  // Map write and read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == CmdClear)
      map_mem[clr_addr_q] <= 1'b0;
    else if (cmd_i.op == CmdLoad && req_type_i == ReqWrite)
      map_mem[{cell_y_i, cell_x_i}] <= cell_wall_i;
    rd_bit_q <= map_mem[{ncy[AddrW-1:0], ncx[AddrW-1:0]}];
  end

  // Clear address counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (cmd_i.op == CmdClear) begin
      clr_addr_q <= clr_addr_q + 1'b1;
    end
  end

  // Ray registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      CmdLoad: begin
        start_q[0] <= start_x_i;
        start_q[1] <= start_y_i;
        neg_q[0]   <= dir_x_i[15];
        neg_q[1]   <= dir_y_i[15];
        mag_q[0]   <= dir_x_i[15] ? 16'(17'h10000 - 17'(dir_x_i)) : dir_x_i;
        mag_q[1]   <= dir_y_i[15] ? 16'(17'h10000 - 17'(dir_y_i)) : dir_y_i;
        cell_q[0]  <= CellW'(start_x_i[StartW-1:FracBits]);
        cell_q[1]  <= CellW'(start_y_i[StartW-1:FracBits]);
        dist_q     <= '0;
        hit_q      <= 1'b0;
        side_q     <= 1'b0;
        gw_q       <= (grid_w_i > 7'(MapDim)) ? 7'(MapDim) : grid_w_i;
        gh_q       <= (grid_h_i > 7'(MapDim)) ? 7'(MapDim) : grid_h_i;
        quo_q      <= '0;
        rem_q      <= '0;
        cnt_q      <= QuotW[$clog2(QuotW+1)-1:0];
      end
      CmdDivStep: begin
        if (dmag == 16'd0) begin
          delta_q[cmd_i.axis] <= DistMax;
        end else if (rem_sh >= {1'b0, dmag}) begin
          rem_q <= rem_sh - {1'b0, dmag};
          quo_q <= {quo_q[QuotW-2:0], 1'b1};
        end else begin
          rem_q <= rem_sh;
          quo_q <= {quo_q[QuotW-2:0], 1'b0};
        end
        if (dmag != 16'd0 && cnt_q == 1) begin
          delta_q[cmd_i.axis] <= DistW'({quo_q[QuotW-2:0], rem_sh >= {1'b0, dmag}});
        end
        cnt_q <= cnt_q - 1'b1;
        if (sts_o.div_done) begin
          cnt_q <= QuotW[$clog2(QuotW+1)-1:0];
          rem_q <= '0;
          quo_q <= '0;
        end
      end
      CmdSideMul: lside_q[cmd_i.axis] <= sat_dist(prod);
      CmdWalk: begin
        if (lx_lt) begin
          cell_q[0]  <= ncx;
          dist_q     <= lside_q[0];
          lside_q[0] <= sat_dist((2*DistW)'(lside_q[0]) + (2*DistW)'(delta_q[0]));
          side_q     <= 1'b0;
        end else begin
          cell_q[1]  <= ncy;
          dist_q     <= lside_q[1];
          lside_q[1] <= sat_dist((2*DistW)'(lside_q[1]) + (2*DistW)'(delta_q[1]));
          side_q     <= 1'b1;
        end
      end
      CmdRead: begin
        if (in_grid && rd_bit_q) hit_q <= 1'b1;
      end
      default: ;
    endcase
  end

  // Outputs, cells saturated to 8 bits
  function automatic logic [7:0] sat8(input logic signed [CellW-1:0] c);
    if (c > 127) sat8 = 8'h7f;
    else if (c < -128) sat8 = 8'h80;
    else sat8 = c[7:0];
  endfunction

  assign hit_o   = hit_q;
  assign side_o  = side_q;
  assign hit_x_o = sat8(cell_q[0]);
  assign hit_y_o = sat8(cell_q[1]);
  assign dist_o  = dist_q;
endmodule

// File: sv/grid_ray_dda_traversal.sv
// Top level of the grid ray DDA traversal block.
// Depends on gdda_pkg, gdda_if, gdda_ctrl and gdda_dp.
//
// After reset the wall map is cleared one cell per cycle, and requests are
// held off until the clear is done. A write request leaves the block ready,
// so the next request can follow at once. A cast request runs the restoring
// divider for the unit step lengths, one axis after the other (one quotient
// bit per cycle; a zero component skips the divide and takes the largest
// step length), then computes the first crossings one axis at a time, then
// walks cell by cell, each step split into a step-and-read state and a check
// state by the registered wall map read. One request is in work at a time.
module grid_ray_dda_traversal (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  gdda_req_if.sink    req_if,
  gdda_res_if.source  res_if
);
  import gdda_pkg::*;

  logic [6:0]  grid_w_q, grid_h_q;
  logic [15:0] far_q;
  gdda_cmd_t   cmd;
  gdda_sts_t   sts;
  logic        hit, side;
  logic [7:0]  hx, hy;
  logic [23:0] ray_len;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_w_q <= 7'd64;
      grid_h_q <= 7'd64;
      far_q    <= 16'd5120;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgGridW: grid_w_q <= cfg_data_i[6:0];
        CfgGridH: grid_h_q <= cfg_data_i[6:0];
        CfgFar:   far_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  gdda_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i  (req_if.valid),
    .in_is_cast_i(req_if.req_type == ReqCast),
    .in_ready_o  (req_if.ready),
    .out_valid_o (res_if.valid),
    .out_ready_i (res_if.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  gdda_dp u_dp (
    .clk_i, .rst_ni,
    .req_type_i (req_if.req_type),
    .cell_x_i   (req_if.cell_x),
    .cell_y_i   (req_if.cell_y),
    .cell_wall_i(req_if.cell_wall),
    .start_x_i  (req_if.start_x),
    .start_y_i  (req_if.start_y),
    .dir_x_i    (req_if.dir_x),
    .dir_y_i    (req_if.dir_y),
    .grid_w_i   (grid_w_q),
    .grid_h_i   (grid_h_q),
    .far_clip_i (far_q),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .hit_o      (hit),
    .side_o     (side),
    .hit_x_o    (hx),
    .hit_y_o    (hy),
    .dist_o     (ray_len)
  );

  assign res_if.hit      = hit;
  assign res_if.hit_side = side;
  assign res_if.hit_x    = hx;
  assign res_if.hit_y    = hy;
  assign res_if.distance = ray_len;
endmodule

// File: sv/gdda_chk.sv
// Port-level checks for grid_ray_dda_traversal, bound to the top level.
// Depends on the top level's port names only.
module gdda_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic in_cast,
  input logic out_valid,
  input logic out_ready,
  input logic out_hit
);
  // A result holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  // No request taken while a result waits
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !in_ready) else $error("request taken with result pending");
  // An accepted cast request blocks the next cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && in_cast |=> !in_ready) else $error("back to back accept");
  // Stalled result keeps its hit flag
  a_hit_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(out_hit)) else $error("hit changed");
endmodule

bind grid_ray_dda_traversal gdda_chk u_chk (
  .clk_i, .rst_ni,
  .in_valid (req_if.valid),
  .in_ready (req_if.ready),
  .in_cast  (req_if.req_type),
  .out_valid(res_if.valid),
  .out_ready(res_if.ready),
  .out_hit  (res_if.hit)
);
